// ----- hw/rtl/rncm_pkg.sv -----
package rncm_pkg;

  // Number of residual norms under test: max, Euclidean squared, h-norm squared
  localparam int NORM_COUNT = 3;
  localparam int NORM_W     = 48;
  localparam int VAL_W      = 32;
  localparam int TOL_W      = 32;
  localparam int GROWTH_W   = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int PROD_W     = NORM_W + TOL_W;

  // Norm lane order
  localparam int NORM_MAX   = 0;
  localparam int NORM_EUCL  = 1;
  localparam int NORM_HNORM = 2;

  localparam logic [1:0] NORM_ALL = 2'(NORM_COUNT);

  // Register reset values
  localparam logic [TOL_W-1:0]    TOL_RESET    = 32'd42950;
  localparam logic [GROWTH_W-1:0] GLIMIT_RESET = 6'd5;

  typedef logic [NORM_W-1:0] norm_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOLERANCE    = 2'd0,
    REG_GROWTH_LIMIT = 2'd1
  } cfg_reg_e;

  // Pipeline controls shared by the norm lanes
  typedef struct packed {
    logic s2_load;  // snapshot moves into the multiply stage
    logic s3_load;  // partial products combine
    logic fire;     // test runs, lane state updates
    logic rc_mul;   // tolerance changed: multiply stored initial value
    logic rc_sum;   // tolerance changed: combine and store product
  } rncm_ctl_t;

endpackage

// ----- hw/rtl/rncm_norm_unit.sv -----
module rncm_norm_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  rncm_pkg::rncm_ctl_t                 ctl,
  input  logic [rncm_pkg::TOL_W-1:0]          tolerance,
  input  rncm_pkg::norm_t                     s1_cur,
  output rncm_pkg::norm_t                     s3_cur,
  output logic                                grown,
  output logic                                reduced
);
  import rncm_pkg::*;

  norm_t               s2_cur;
  logic [63:0]         s2_lo;
  logic [47:0]         s2_hi;
  logic [PROD_W-1:0]   s3_prod;
  norm_t               init_val;
  logic [PROD_W-1:0]   init_prod;
  norm_t               prev_val;
  logic [63:0]         rc_lo;
  logic [47:0]         rc_hi;
  logic                init_zero;
  logic [NORM_W+2:0]   cur5;
  logic [NORM_W+2:0]   prev6;

  // Split tolerance * cur into a 32x32 and a 32x16 partial product
  always_ff @(posedge clk) begin
    if (ctl.s2_load) begin
      s2_cur <= s1_cur;
      s2_lo  <= 64'(tolerance) * 64'(s1_cur[31:0]);
      s2_hi  <= 48'(tolerance) * 48'(s1_cur[47:32]);
    end
  end

  // Combine partials into the full tolerance product
  always_ff @(posedge clk) begin
    if (ctl.s3_load) begin
      s3_cur  <= s2_cur;
      s3_prod <= {s2_hi, 32'b0} + PROD_W'(s2_lo);
    end
  end

  // Growth over 1.2x and reduction below tolerance * initial
  always_comb begin
    init_zero = (init_val == '0);
    cur5      = (NORM_W+3)'({s3_cur, 2'b00}) + (NORM_W+3)'(s3_cur);
    prev6     = (NORM_W+3)'({prev_val, 2'b00}) + (NORM_W+3)'({prev_val, 1'b0});
    grown     = !init_zero && (prev6 < cur5);
    reduced   = !init_zero && !grown && ({s3_cur, 32'b0} < init_prod);
  end

  // Latch initial value on first nonzero-able test, always track previous
  always_ff @(posedge clk) begin
    if (rst) begin
      init_val <= '0;
      prev_val <= '0;
    end else if (ctl.fire) begin
      if (init_zero) begin
        init_val <= s3_cur;
      end
      prev_val <= s3_cur;
    end
  end

  // Rebuild the stored product after a tolerance write
  always_ff @(posedge clk) begin
    if (ctl.rc_mul) begin
      rc_lo <= 64'(tolerance) * 64'(init_val[31:0]);
      rc_hi <= 48'(tolerance) * 48'(init_val[47:32]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire && init_zero) begin
      init_prod <= s3_prod;
    end else if (ctl.rc_sum) begin
      init_prod <= {rc_hi, 32'b0} + PROD_W'(rc_lo);
    end
  end

endmodule

// ----- hw/rtl/residual_norm_convergence_monitor_core.sv -----
// Channel  | handshake          | word
// ---------+--------------------+-------------------------------------------------
// input    | in_valid/in_stall  | cell_max_norm, cell_eucl_sq, cell_hnorm_sq,
//          |                    | mesh_width, sweep_last
// output   | out_valid/out_stall| terminate, counts, growth_events, sweep aggregates
// config   | cfg_wr_en          | cfg_index, cfg_wdata
//
// One input word per cycle while in_stall is low; accumulation is done at the accept edge.
// A sweep_last word is registered in s1, then in the s2 and s3 stages of the
// two-stage split 32x48 tolerance multiply, then in the output register after the test stage.
// Reset clears accumulators, initial/previous norms, the growth count and
// restores both registers; no clearing pass is needed.
// A stalled output holds its word; only sweep_last words travel down the pipe, so
// input stalls only when three sweep-end words back up behind the output.
module residual_norm_convergence_monitor_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [rncm_pkg::VAL_W-1:0]         cell_max_norm,
  input  logic [rncm_pkg::VAL_W-1:0]         cell_eucl_sq,
  input  logic [rncm_pkg::VAL_W-1:0]         cell_hnorm_sq,
  input  logic [rncm_pkg::VAL_W-1:0]         mesh_width,
  input  logic                               sweep_last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               terminate,
  output logic [1:0]                         reduced_count,
  output logic [1:0]                         grow_count,
  output logic [rncm_pkg::GROWTH_W-1:0]      growth_events,
  output logic [rncm_pkg::VAL_W-1:0]         sweep_max_norm,
  output logic [rncm_pkg::NORM_W-1:0]        sweep_eucl_sq,
  output logic [rncm_pkg::NORM_W-1:0]        sweep_hnorm_sq,
  output logic [rncm_pkg::VAL_W-1:0]         min_width,
  output logic [rncm_pkg::VAL_W-1:0]         max_width,
  input  logic                               cfg_wr_en,
  input  logic [rncm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rncm_pkg::TOL_W-1:0]         cfg_wdata
);
  import rncm_pkg::*;

  logic [TOL_W-1:0]    tolerance;
  logic [GROWTH_W-1:0] growth_limit;
  logic [GROWTH_W-1:0] growth_total;
  logic [GROWTH_W-1:0] growth_next;

  logic [VAL_W-1:0]    acc_max_norm;
  norm_t               acc_eucl_sq;
  norm_t               acc_hnorm_sq;
  logic [VAL_W-1:0]    acc_min_width;
  logic [VAL_W-1:0]    acc_max_width;

  logic [VAL_W-1:0]    max_norm_next;
  norm_t               eucl_next;
  norm_t               hnorm_next;
  logic [NORM_W:0]     eucl_sum;
  logic [NORM_W:0]     hnorm_sum;
  logic [VAL_W-1:0]    min_width_next;
  logic [VAL_W-1:0]    max_width_next;

  logic                s1_valid;
  logic                s2_valid;
  logic                s3_valid;
  norm_t               s1_cur [NORM_COUNT];
  norm_t               s3_cur [NORM_COUNT];
  logic [VAL_W-1:0]    s1_wmin, s2_wmin, s3_wmin;
  logic [VAL_W-1:0]    s1_wmax, s2_wmax, s3_wmax;

  logic                accept;
  logic                out_free;
  logic                fire;
  logic                s3_ready;
  logic                s2_move;
  logic                s2_ready;
  logic                s1_move;
  logic                rc_mul;
  logic                rc_sum;
  rncm_ctl_t           ctl;

  logic [NORM_COUNT-1:0] grown;
  logic [NORM_COUNT-1:0] reduced;
  logic [1:0]            grow_cnt;
  logic [1:0]            red_cnt;

  // Pipeline flow: each stage moves when the one ahead frees up
  assign out_free = !out_valid || !out_stall;
  assign fire     = s3_valid && out_free;
  assign s3_ready = !s3_valid || fire;
  assign s2_move  = s2_valid && s3_ready;
  assign s2_ready = !s2_valid || s2_move;
  assign s1_move  = s1_valid && s2_ready;
  assign in_stall = s1_valid && !s1_move;
  assign accept   = in_valid && !in_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance    <= TOL_RESET;
      growth_limit <= GLIMIT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TOLERANCE:    tolerance    <= cfg_wdata;
        REG_GROWTH_LIMIT: growth_limit <= cfg_wdata[GROWTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequence the stored-product rebuild after a tolerance write
  always_ff @(posedge clk) begin
    if (rst) begin
      rc_mul <= 1'b0;
      rc_sum <= 1'b0;
    end else begin
      rc_mul <= cfg_wr_en && (cfg_index == REG_TOLERANCE);
      rc_sum <= rc_mul;
    end
  end

  // Fold the incoming word into the sweep aggregates
  always_comb begin
    max_norm_next  = (cell_max_norm > acc_max_norm) ? cell_max_norm : acc_max_norm;
    eucl_sum       = (NORM_W+1)'(acc_eucl_sq) + (NORM_W+1)'(cell_eucl_sq);
    hnorm_sum      = (NORM_W+1)'(acc_hnorm_sq) + (NORM_W+1)'(cell_hnorm_sq);
    eucl_next      = eucl_sum[NORM_W] ? '1 : eucl_sum[NORM_W-1:0];
    hnorm_next     = hnorm_sum[NORM_W] ? '1 : hnorm_sum[NORM_W-1:0];
    min_width_next = (mesh_width < acc_min_width) ? mesh_width : acc_min_width;
    max_width_next = (mesh_width > acc_max_width) ? mesh_width : acc_max_width;
  end

  // Accumulate, or clear at the end of a sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_max_norm  <= '0;
      acc_eucl_sq   <= '0;
      acc_hnorm_sq  <= '0;
      acc_min_width <= '1;
      acc_max_width <= '0;
    end else if (accept) begin
      if (sweep_last) begin
        acc_max_norm  <= '0;
        acc_eucl_sq   <= '0;
        acc_hnorm_sq  <= '0;
        acc_min_width <= '1;
        acc_max_width <= '0;
      end else begin
        acc_max_norm  <= max_norm_next;
        acc_eucl_sq   <= eucl_next;
        acc_hnorm_sq  <= hnorm_next;
        acc_min_width <= min_width_next;
        acc_max_width <= max_width_next;
      end
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (accept && sweep_last) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        s2_valid <= 1'b1;
      end else if (s2_move) begin
        s2_valid <= 1'b0;
      end
      if (s2_move) begin
        s3_valid <= 1'b1;
      end else if (fire) begin
        s3_valid <= 1'b0;
      end
    end
  end

  // Snapshot the finished sweep
  always_ff @(posedge clk) begin
    if (accept && sweep_last) begin
      s1_cur[NORM_MAX]   <= NORM_W'(max_norm_next);
      s1_cur[NORM_EUCL]  <= eucl_next;
      s1_cur[NORM_HNORM] <= hnorm_next;
      s1_wmin            <= min_width_next;
      s1_wmax            <= max_width_next;
    end
  end

  // Carry the widths alongside the multiply stages
  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_wmin <= s1_wmin;
      s2_wmax <= s1_wmax;
    end
    if (s2_move) begin
      s3_wmin <= s2_wmin;
      s3_wmax <= s2_wmax;
    end
  end

  assign ctl.s2_load = s1_move;
  assign ctl.s3_load = s2_move;
  assign ctl.fire    = fire;
  assign ctl.rc_mul  = rc_mul;
  assign ctl.rc_sum  = rc_sum;

  for (genvar g = 0; g < NORM_COUNT; g++) begin : g_norm
    rncm_norm_unit u_norm (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .tolerance (tolerance),
      .s1_cur    (s1_cur[g]),
      .s3_cur    (s3_cur[g]),
      .grown     (grown[g]),
      .reduced   (reduced[g])
    );
  end

  // Count grown and reduced norms, advance the saturating growth count
  always_comb begin
    grow_cnt = '0;
    red_cnt  = '0;
    for (int i = 0; i < NORM_COUNT; i++) begin
      grow_cnt = grow_cnt + 2'(grown[i]);
      red_cnt  = red_cnt + 2'(reduced[i]);
    end
    growth_next = growth_total;
    if ((grow_cnt == NORM_ALL) && (growth_total != '1)) begin
      growth_next = growth_total + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      growth_total <= '0;
    end else if (fire) begin
      growth_total <= growth_next;
    end
  end

  assign growth_events = growth_total;

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      terminate      <= (red_cnt == NORM_ALL) || (growth_next > growth_limit);
      reduced_count  <= red_cnt;
      grow_count     <= grow_cnt;
      sweep_max_norm <= s3_cur[NORM_MAX][VAL_W-1:0];
      sweep_eucl_sq  <= s3_cur[NORM_EUCL];
      sweep_hnorm_sq <= s3_cur[NORM_HNORM];
      min_width      <= s3_wmin;
      max_width      <= s3_wmax;
    end
  end

endmodule

// ----- hw/rtl/rncm_checker.sv -----
module rncm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          terminate,
  input logic [1:0]                    reduced_count,
  input logic [1:0]                    grow_count,
  input logic [rncm_pkg::VAL_W-1:0]    min_width,
  input logic [rncm_pkg::VAL_W-1:0]    max_width
);
  import rncm_pkg::*;

  // A stalled result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(reduced_count) && $stable(grow_count)
      && $stable(terminate) && $stable(min_width) && $stable(max_width))
    else $error("result word changed while stalled");

  // A norm is counted as grown or reduced, never both
  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, reduced_count} + {1'b0, grow_count}) <= 3'(NORM_COUNT))
    else $error("grown plus reduced exceeds norm count");

  // All norms reduced must terminate
  a_all_reduced: assert property (@(posedge clk) disable iff (rst)
    out_valid && (reduced_count == NORM_ALL) |-> terminate)
    else $error("all norms reduced without terminate");

  // Every sweep holds at least its last cell
  a_width_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> min_width <= max_width)
    else $error("min width above max width");

endmodule

bind residual_norm_convergence_monitor_core rncm_checker u_rncm_checker (.*);
